[rtl/core/cas_pkg.sv]
// shared types, constants and the cell rule for the cave smoothing step
`timescale 1ns / 1ps
`default_nettype none

package cas_pkg;

   // largest row the line buffer is built for
   localparam int CAS_MAX_WIDTH = 256;
   // hard ceiling on both grid dimensions
   localparam int CAS_DIM_MAX   = 256;
   localparam int CAS_DIM_MIN   = 3;

   // configuration register indexes
   localparam logic REG_GRID_WIDTH  = 1'b0;
   localparam logic REG_GRID_HEIGHT = 1'b1;

   // smoothing thresholds
   localparam logic [3:0] BIRTH_ABOVE = 4'd4;
   localparam logic [3:0] DEATH_BELOW = 4'd3;

   // one accepted grid position on its way to the evaluation stage
   typedef struct packed {
      logic       bot;      // cell of the current row
      logic       mid_en;   // row above exists
      logic       top_en;   // row two above exists
      logic       wrap;     // column zero: emit the shifted window, then restart it
      logic       emit;     // this position produces a result
      logic       last;     // result is the final cell of the grid
      logic [7:0] row;
      logic [7:0] col;
   } stage_type;

   // new value of the centre cell of a 3x3 window (centre is bit 4)
   function automatic logic cas_decide(input logic [8:0] w);
      logic [3:0] n;
      logic       centre;
      n      = 4'd0;
      centre = w[4];
      for (int b = 0; b < 9; b++) begin
         if (b != 4) begin
            n = n + {3'd0, w[b]};
         end
      end
      if (!centre && (n > BIRTH_ABOVE)) begin
         return 1'b1;
      end
      if (centre && (n < DEATH_BELOW)) begin
         return 1'b0;
      end
      return centre;
   endfunction

endpackage

`default_nettype wire

[rtl/core/cas_line_buf.sv]
// two-row line buffer, one registered read and one write per cycle
`timescale 1ns / 1ps
`default_nettype none

module cas_line_buf #(
   parameter int DEPTH = 256
) (
   input  wire logic                       clock,
   input  wire logic                       rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic      [1:0]                 rd_data,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire logic [1:0]                 wr_data
);

   // bit 1 = two rows up, bit 0 = one row up
   logic [1:0] mem_ff [DEPTH];
   logic [1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/core/cas_scan.sv]
// config registers, raster position tracking and the input stage register
`timescale 1ns / 1ps
`default_nettype none

module cas_scan #(
   parameter int DEPTH = 256
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic                       csr_index,
   input  wire logic [8:0]                 csr_data,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic                       req_mode,
   input  wire logic                       req_cell,
   input  wire logic                       adv,
   output logic                            s1_valid,
   output cas_pkg::stage_type              s1,
   output logic [$clog2(DEPTH)-1:0]        s1_addr,
   output logic                            rd_en,
   output logic [$clog2(DEPTH)-1:0]        rd_addr
);
   import cas_pkg::*;

   localparam int AW = $clog2(DEPTH);

   logic [8:0]      grid_width_ff, grid_width_in;
   logic [8:0]      grid_height_ff, grid_height_in;
   logic [8:0]      in_row_ff, in_row_in;
   logic [AW-1:0]   in_col_ff, in_col_in;
   logic            s1_valid_ff, s1_valid_in;
   stage_type       s1_ff, s1_in;
   logic [AW-1:0]   s1_addr_ff;

   logic [8:0]      wid_m1_w;
   logic [AW-1:0]   wid_m1;
   logic [7:0]      hgt_m1;
   logic [8:0]      hgt_m1_w;
   logic            csr_wr, accept, is_grid, load, at_c0;
   logic [8:0]      row_back;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;

   // clamp the dimensions to what the grid and the buffer allow
   always_comb begin
      if (grid_width_ff < 9'(CAS_DIM_MIN)) begin
         wid_m1_w = 9'(CAS_DIM_MIN - 1);
      end else if (grid_width_ff > 9'(DEPTH)) begin
         wid_m1_w = 9'(DEPTH - 1);
      end else begin
         wid_m1_w = grid_width_ff - 9'd1;
      end
      if (grid_height_ff < 9'(CAS_DIM_MIN)) begin
         hgt_m1_w = 9'(CAS_DIM_MIN - 1);
      end else if (grid_height_ff > 9'(CAS_DIM_MAX)) begin
         hgt_m1_w = 9'(CAS_DIM_MAX - 1);
      end else begin
         hgt_m1_w = grid_height_ff - 9'd1;
      end
   end
   assign wid_m1 = wid_m1_w[AW-1:0];
   assign hgt_m1 = hgt_m1_w[7:0];

   assign req_tready = !s1_valid_ff || adv;
   assign accept     = req_tvalid && req_tready;
   assign is_grid    = in_row_ff <= {1'b0, hgt_m1};
   // a drain request while grid cells are still due is dropped
   assign load       = accept && !(is_grid && req_mode);
   assign at_c0      = in_col_ff == '0;
   assign row_back   = at_c0 ? (in_row_ff - 9'd2) : (in_row_ff - 9'd1);

   always_comb begin
      s1_in.bot    = is_grid ? req_cell : 1'b0;
      s1_in.mid_en = in_row_ff >= 9'd1;
      s1_in.top_en = in_row_ff >= 9'd2;
      s1_in.wrap   = at_c0;
      s1_in.emit   = at_c0 ? (in_row_ff >= 9'd2) : (in_row_ff >= 9'd1);
      s1_in.row    = row_back[7:0];
      s1_in.col    = at_c0 ? 8'(wid_m1) : 8'(in_col_ff - AW'(1));
      s1_in.last   = s1_in.emit && (s1_in.row == hgt_m1) && (s1_in.col == 8'(wid_m1));
   end

   always_comb begin
      grid_width_in  = grid_width_ff;
      grid_height_in = grid_height_ff;
      in_row_in      = in_row_ff;
      in_col_in      = in_col_ff;
      if (csr_wr) begin
         unique case (csr_index)
            REG_GRID_WIDTH:  grid_width_in  = csr_data;
            REG_GRID_HEIGHT: grid_height_in = csr_data;
            default:         grid_width_in  = grid_width_ff;
         endcase
         in_row_in = '0;
         in_col_in = '0;
      end else if (load) begin
         if (s1_in.last) begin
            in_row_in = '0;
            in_col_in = '0;
         end else if (in_col_ff == wid_m1) begin
            in_col_in = '0;
            in_row_in = in_row_ff + 9'd1;
         end else begin
            in_col_in = in_col_ff + AW'(1);
         end
      end
   end

   always_comb begin
      if (load) begin
         s1_valid_in = 1'b1;
      end else if (adv) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= 9'd64;
         grid_height_ff <= 9'd64;
         in_row_ff      <= '0;
         in_col_ff      <= '0;
         s1_valid_ff    <= 1'b0;
      end else begin
         grid_width_ff  <= grid_width_in;
         grid_height_ff <= grid_height_in;
         in_row_ff      <= in_row_in;
         in_col_ff      <= in_col_in;
         s1_valid_ff    <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s1_ff      <= s1_in;
         s1_addr_ff <= in_col_ff;
      end
   end

   assign s1_valid = s1_valid_ff;
   assign s1       = s1_ff;
   assign s1_addr  = s1_addr_ff;
   assign rd_en    = load;
   assign rd_addr  = in_col_ff;

endmodule

`default_nettype wire

[rtl/core/cas_eval.sv]
// window shift, cell rule and the result register
`timescale 1ns / 1ps
`default_nettype none

module cas_eval (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                s1_valid,
   input  wire cas_pkg::stage_type  s1,
   input  wire logic [1:0]          rd_data,
   output logic                     adv,
   output logic                     wr_en,
   output logic [1:0]               wr_data,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [23:0]              rsp_tdata,
   output logic                     rsp_tlast
);
   import cas_pkg::*;

   logic [8:0]  window_ff, window_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [16:0] rsp_data_ff;
   logic        rsp_last_ff;
   logic        top, mid, slot_free;
   logic [2:0]  col;
   logic [8:0]  view;

   assign top = rd_data[1] && s1.top_en;
   assign mid = rd_data[0] && s1.mid_en;
   assign col = {top, mid, s1.bot};

   // at column zero the finished row end is shifted out and the window restarts
   assign window_in = s1.wrap ? {6'd0, col} : {window_ff[5:0], col};
   assign view      = s1.wrap ? {window_ff[5:0], 3'd0} : window_in;

   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign adv       = s1_valid && (!s1.emit || slot_free);
   assign wr_en     = adv;
   assign wr_data   = {mid, s1.bot};

   always_comb begin
      if (adv && s1.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         window_ff <= window_in;
      end
      if (adv && s1.emit) begin
         rsp_data_ff <= {s1.col, s1.row, cas_decide(view)};
         rsp_last_ff <= s1.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_data_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

[rtl/core/cave_automaton_smoothing_step.sv]
// top level of the one-generation cave smoothing step over a raster cell stream
// the request that completes a window passes the stage register, then the result register
// results trail the input by one row plus one cell; drain requests flush the tail
// throughput: one request per cycle, limited only by rsp_tready backpressure
// reset: grid 64 x 64, position and pipeline cleared; line buffer needs no clearing
`timescale 1ns / 1ps
`default_nettype none

module cave_automaton_smoothing_step #(
   parameter int MAX_WIDTH = cas_pkg::CAS_MAX_WIDTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [0] cell_in, rest zero
   input  wire logic        req_tuser,   // [0] mode (1 = drain)
   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // [0] cell_out, [8:1] out_row, [16:9] out_col
   output logic             rsp_tlast,   // frame_last
   // configuration writes
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,   // 0 grid_width, 1 grid_height
   input  wire logic [8:0]  csr_data
);
   import cas_pkg::*;

   // rows wider than the grid limit never occur, so the buffer stops there
   localparam int DEPTH = (MAX_WIDTH < CAS_DIM_MAX) ? MAX_WIDTH : CAS_DIM_MAX;
   localparam int AW    = $clog2(DEPTH);

   logic            s1_valid;
   stage_type       s1;
   logic [AW-1:0]   s1_addr;
   logic            adv;
   logic            rd_en;
   logic [AW-1:0]   rd_addr;
   logic [1:0]      rd_data;
   logic            wr_en;
   logic [1:0]      wr_data;

   // position counters, dimension clamp and the request register
   cas_scan #(
      .DEPTH(DEPTH)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_mode   (req_tuser),
      .req_cell   (req_tdata[0]),
      .adv        (adv),
      .s1_valid   (s1_valid),
      .s1         (s1),
      .s1_addr    (s1_addr),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr)
   );

   // the two rows above, read as the request is registered
   cas_line_buf #(
      .DEPTH(DEPTH)
   ) u_line (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (s1_addr),
      .wr_data (wr_data)
   );

   // window, rule and result register
   cas_eval u_eval (
      .clock      (clock),
      .reset      (reset),
      .s1_valid   (s1_valid),
      .s1         (s1),
      .rd_data    (rd_data),
      .adv        (adv),
      .wr_en      (wr_en),
      .wr_data    (wr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

[rtl/core/cas_checker.sv]
// port-level checks for the cave smoothing step, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module cas_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata,
   input wire logic        rsp_tlast
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // reset empties the result register
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result pending after reset");

   // requests only stall when the result side does
   a_req_flow: assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid || rsp_tready) |-> req_tready)
      else $error("request stalled with free result slot");

   // the final cell sits at least three rows and columns in
   a_last_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> (rsp_tdata[8:1] >= 8'd2) && (rsp_tdata[16:9] >= 8'd2))
      else $error("frame end at impossible position");

endmodule

bind cave_automaton_smoothing_step cas_checker u_cas_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
